@@ design/sha1_digest_defines.svh @@
// ----------------------------------------------------------------------------
// sha1_digest_defines : assertion macros for the sha1 digest block
// the including module provides clk and rst_n
// ----------------------------------------------------------------------------
`ifndef SHA1_DIGEST_DEFINES_SVH
`define SHA1_DIGEST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SHA1_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SHA1_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and the final-word padding function
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int unsigned BufDepth  = 16;
  localparam int unsigned HashWords = 5;

  typedef logic [31:0] word_t;
  typedef logic [3:0]  bidx_t;
  typedef logic [2:0]  hidx_t;

  localparam word_t PAD_MARK = 32'h8000_0000;

  // block buffer write port
  typedef struct packed {
    logic  we;
    bidx_t addr;
    word_t data;
  } sha1_bwr_t;

  // compression command from the sequencer
  typedef struct packed {
    logic start;
    logic final_blk;
  } sha1_cmd_t;

  // compression engine status
  typedef struct packed {
    logic busy;
    logic done;
  } sha1_sts_t;

  // digest word written back on the last compression of a message
  typedef struct packed {
    logic  we;
    hidx_t idx;
    word_t data;
  } sha1_dig_t;

  // keep valid top bytes, 0x80 marker right after; cnt 4 to 7 leaves w as is
  function automatic word_t pad_word(input word_t w, input logic [2:0] cnt);
    word_t r;
    case (cnt)
      3'd0:    r = PAD_MARK;
      3'd1:    r = {w[31:24], 24'h80_0000};
      3'd2:    r = {w[31:16], 16'h8000};
      3'd3:    r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/sha1_bufmem.sv @@
// ----------------------------------------------------------------------------
// sha1_bufmem
// 16 x 32 message block memory, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_bufmem (
  input  wire logic               clk,
  input  wire sha1_pkg::sha1_bwr_t wr,
  input  wire sha1_pkg::bidx_t    raddr,
  output sha1_pkg::word_t         rdata
);
  import sha1_pkg::*;

  word_t mem [BufDepth];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/sha1_core.sv @@
// ----------------------------------------------------------------------------
// sha1_core
// 80-round compression engine with the chaining value kept in a small memory
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha1_pkg::sha1_cmd_t cmd,
  output sha1_pkg::sha1_sts_t     sts,
  output sha1_pkg::sha1_dig_t     dig,
  output sha1_pkg::bidx_t         buf_raddr,
  input  wire sha1_pkg::word_t    buf_rdata
);
  import sha1_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE  = 4'b0001,
    P_LOAD  = 4'b0010,
    P_ROUND = 4'b0100,
    P_STORE = 4'b1000
  } phase_t;

  localparam logic [6:0] LastStep  = 7'd5;
  localparam logic [6:0] LastRound = 7'd79;

  function automatic word_t iv_word(input hidx_t i);
    word_t r;
    case (i)
      3'd0:    r = 32'h6745_2301;
      3'd1:    r = 32'hefcd_ab89;
      3'd2:    r = 32'h98ba_dcfe;
      3'd3:    r = 32'h1032_5476;
      default: r = 32'hc3d2_e1f0;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] r);
    word_t k;
    if (r < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  function automatic word_t round_f(input logic [6:0] r, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r >= 7'd40 && r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       final_r, final_nxt;
  logic       fresh_r, fresh_nxt;

  word_t hash_mem [HashWords];
  word_t hash_rd_r;
  word_t work_r [HashWords];
  word_t win_r [BufDepth];

  hidx_t hash_raddr;
  hidx_t step_idx;
  word_t hash_q;
  logic  hash_we;
  word_t hash_sum;
  word_t w_cur;
  word_t t_sum;

  // step index trails the read address by one, matching the registered read
  assign step_idx   = cnt_r[2:0] - 3'd1;
  assign hash_raddr = (cnt_r < LastStep) ? cnt_r[2:0] : '0;
  // chaining value reads as the initial value after reset or a final write-back
  assign hash_q     = fresh_r ? iv_word(step_idx) : hash_rd_r;
  assign hash_sum   = hash_q + work_r[step_idx];
  assign hash_we    = (phase_r == P_STORE) && (cnt_r != '0);

  assign buf_raddr  = (phase_r == P_ROUND) ? (cnt_r[3:0] + 4'd1) : '0;

  // schedule: first 16 words from the buffer, then expanded from the window
  always_comb begin
    if (cnt_r < 7'd16) begin
      w_cur = buf_rdata;
    end else begin
      w_cur = win_r[2] ^ win_r[7] ^ win_r[13] ^ win_r[15];
      w_cur = {w_cur[30:0], w_cur[31]};
    end
  end

  assign t_sum = {work_r[0][26:0], work_r[0][31:27]}
               + round_f(cnt_r, work_r[1], work_r[2], work_r[3])
               + work_r[4] + w_cur + round_k(cnt_r);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    final_nxt = final_r;
    fresh_nxt = fresh_r;
    case (phase_r)
      P_IDLE: begin
        if (cmd.start) begin
          phase_nxt = P_LOAD;
          cnt_nxt   = '0;
          final_nxt = cmd.final_blk;
        end
      end
      P_LOAD: begin
        if (cnt_r == LastStep) begin
          phase_nxt = P_ROUND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      P_ROUND: begin
        if (cnt_r == LastRound) begin
          phase_nxt = P_STORE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      P_STORE: begin
        if (cnt_r == LastStep) begin
          phase_nxt = P_IDLE;
          cnt_nxt   = '0;
          fresh_nxt = final_r;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      cnt_r   <= '0;
      final_r <= 1'b0;
      fresh_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      final_r <= final_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // chaining value memory: read-modify-write, entry j written while j+1 is read
  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[step_idx] <= hash_sum;
    end
    hash_rd_r <= hash_mem[hash_raddr];
  end

  // working registers a..e and the schedule window
  always_ff @(posedge clk) begin
    if (phase_r == P_LOAD && cnt_r != '0) begin
      work_r[step_idx] <= hash_q;
    end else if (phase_r == P_ROUND) begin
      work_r[0] <= t_sum;
      work_r[1] <= work_r[0];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
      win_r[0]  <= w_cur;
      for (int i = 1; i < BufDepth; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  assign sts.busy  = (phase_r != P_IDLE);
  assign sts.done  = (phase_r == P_STORE) && (cnt_r == LastStep);
  assign dig.we    = hash_we && final_r;
  assign dig.idx   = step_idx;
  assign dig.data  = hash_sum;

endmodule

`default_nettype wire

@@ design/sha1_digest.sv @@
// sha1_digest: ordinary item goes straight into the block buffer; every 16th word starts a compression
// with ready low while the engine loads the chaining value, runs 80 rounds, writes back
// final item: 2 to 18 padding writes, one or two compressions, then five digest
// items at one per cycle while out_ready is high, from an output buffer;
// non-final items of the next message are taken while the digest drains
// reset: synchronous, active low; chaining value reads as the initial value, no clearing pass
// ----------------------------------------------------------------------------
// sha1_digest
// sha1 hash over one message per run, big-endian 32-bit words in, 5 words out
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_digest_defines.svh"

module sha1_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1_pkg::*;

  // sequencer states: taking words, writing padding, waiting on compression
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PAD  = 3'b010,
    S_HASH = 3'b100
  } st_t;

  localparam bidx_t LenHiIdx = 4'd14;
  localparam bidx_t LastIdx  = 4'd15;
  localparam hidx_t LastDig  = 3'd4;

  st_t         state_r, state_nxt;
  bidx_t       idx_r, idx_nxt;          // next free buffer entry
  logic [63:0] bit_len_r, bit_len_nxt;  // message length in bits
  logic        pad_r, pad_nxt;          // message end seen, padding running
  logic        mark_r, mark_nxt;        // 0x80 marker still to be written
  logic        two_r, two_nxt;          // length goes into the following block
  logic        len_r, len_nxt;          // length written, next compression is the last
  logic        out_busy_r, out_busy_nxt;
  hidx_t       out_idx_r, out_idx_nxt;
  word_t       dig_r [HashWords];

  sha1_bwr_t   buf_wr;
  bidx_t       buf_raddr;
  word_t       buf_rdata;
  sha1_cmd_t   core_cmd;
  sha1_sts_t   core_sts;
  sha1_dig_t   core_dig;

  logic        in_acc;
  logic        out_acc;
  logic [2:0]  cnt_sat;

  // a final item waits until the previous digest has drained
  assign in_ready = (state_r == S_IDLE) && !(in_last && out_busy_r);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  // byte counts above four on the final item count as four
  assign cnt_sat  = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    bit_len_nxt  = bit_len_r;
    pad_nxt      = pad_r;
    mark_nxt     = mark_r;
    two_nxt      = two_r;
    len_nxt      = len_r;
    buf_wr.we    = 1'b0;
    buf_wr.addr  = idx_r;
    buf_wr.data  = in_data_word;
    core_cmd.start     = 1'b0;
    core_cmd.final_blk = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          buf_wr.we = 1'b1;
          idx_nxt   = idx_r + 4'd1;
          if (!in_last) begin
            // ordinary word: always four bytes
            bit_len_nxt = bit_len_r + 64'd32;
          end else begin
            bit_len_nxt = bit_len_r + {58'd0, cnt_sat, 3'd0};
            buf_wr.data = pad_word(in_data_word, cnt_sat);
            pad_nxt     = 1'b1;
            len_nxt     = 1'b0;
            // full final word pushes the marker into the next entry
            mark_nxt    = (cnt_sat == 3'd4);
            two_nxt     = (cnt_sat != 3'd4) && (idx_r == LenHiIdx);
            state_nxt   = S_PAD;
          end
          if (idx_r == LastIdx) begin
            // block full: compress before anything else
            two_nxt        = 1'b0;
            core_cmd.start = 1'b1;
            state_nxt      = S_HASH;
          end
        end
      end

      S_PAD: begin
        buf_wr.we = 1'b1;
        idx_nxt   = idx_r + 4'd1;
        if (mark_r) begin
          buf_wr.data = PAD_MARK;
          mark_nxt    = 1'b0;
          two_nxt     = (idx_r == LenHiIdx);
        end else if (idx_r == LenHiIdx && !two_r) begin
          buf_wr.data = bit_len_r[63:32];
        end else if (idx_r == LastIdx && !two_r) begin
          buf_wr.data = bit_len_r[31:0];
          len_nxt     = 1'b1;
        end else begin
          buf_wr.data = '0;
        end
        if (idx_r == LastIdx) begin
          two_nxt            = 1'b0;
          core_cmd.start     = 1'b1;
          core_cmd.final_blk = !mark_r && !two_r;
          state_nxt          = S_HASH;
        end
      end

      S_HASH: begin
        if (core_sts.done) begin
          if (len_r) begin
            // message complete: start over with a zero length
            state_nxt   = S_IDLE;
            pad_nxt     = 1'b0;
            len_nxt     = 1'b0;
            bit_len_nxt = '0;
          end else if (pad_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // digest output buffer drains one word per item
  always_comb begin
    out_busy_nxt = out_busy_r;
    out_idx_nxt  = out_idx_r;
    if (state_r == S_HASH && core_sts.done && len_r) begin
      out_busy_nxt = 1'b1;
      out_idx_nxt  = '0;
    end else if (out_acc) begin
      if (out_idx_r == LastDig) begin
        out_busy_nxt = 1'b0;
      end else begin
        out_idx_nxt = out_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      bit_len_r  <= '0;
      pad_r      <= 1'b0;
      mark_r     <= 1'b0;
      two_r      <= 1'b0;
      len_r      <= 1'b0;
      out_busy_r <= 1'b0;
      out_idx_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      bit_len_r  <= bit_len_nxt;
      pad_r      <= pad_nxt;
      mark_r     <= mark_nxt;
      two_r      <= two_nxt;
      len_r      <= len_nxt;
      out_busy_r <= out_busy_nxt;
      out_idx_r  <= out_idx_nxt;
    end
  end

  // digest words land here during the last write-back
  always_ff @(posedge clk) begin
    if (core_dig.we) begin
      dig_r[core_dig.idx] <= core_dig.data;
    end
  end

  assign out_valid       = out_busy_r;
  assign out_digest_word = dig_r[out_idx_r];
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == LastDig);

  sha1_bufmem u_bufmem (
    .clk   (clk),
    .wr    (buf_wr),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  sha1_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (core_cmd),
    .sts       (core_sts),
    .dig       (core_dig),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata)
  );

  // compression is only started on an idle engine
  `SHA1_ASSERT_IMP(a_start_idle, core_cmd.start, !core_sts.busy, "start while engine busy")
  // digest write-back never overwrites words still draining
  `SHA1_ASSERT_IMP(a_dig_free, core_dig.we, !out_busy_r, "digest overwrite")
  // waiting state always has a running engine
  `SHA1_ASSERT_IMP(a_hash_busy, state_r == S_HASH, core_sts.busy, "wait without engine")
  // output only starts after the length block finished
  `SHA1_ASSERT_IMP(a_out_start, $rose(out_busy_r), $past(core_sts.done && len_r),
                   "digest without final compression")

endmodule

`default_nettype wire

@@ tb/sha1_digest_tb.sv @@
// ----------------------------------------------------------------------------
// sha1_digest_tb : self-checking bench for the sha1 digest block
// streams messages of big-endian words through the input channel, hashes each
// accepted item in a local sha1 model and compares every digest item that
// comes back, with random idling on both channels and one long output hold
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_digest_tb;

  import sha1_pkg::*;

  localparam int unsigned HALF_PERIOD = 4;
  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // two back-to-back compressions plus the digest drain, with margin
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_SHOWN = 10;

  localparam word_t H0_INIT = 32'h6745_2301;
  localparam word_t H1_INIT = 32'hefcd_ab89;
  localparam word_t H2_INIT = 32'h98ba_dcfe;
  localparam word_t H3_INIT = 32'h1032_5476;
  localparam word_t H4_INIT = 32'hc3d2_e1f0;

  localparam word_t K_CHOOSE = 32'h5a82_7999;
  localparam word_t K_PARITY_LO = 32'h6ed9_eba1;
  localparam word_t K_MAJORITY = 32'h8f1b_bcdc;
  localparam word_t K_PARITY_HI = 32'hca62_c1d6;

  localparam logic [2:0] FULL_WORD = 3'd4;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_item_t;

  // dut ports, inputs driven to known values from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // local hash state, mirrors what the block holds between items
  word_t       chain_h [HashWords];
  word_t       blk_words [BufDepth];
  logic [63:0] msg_bits;
  int unsigned fill_idx;

  digest_item_t digest_q [$];

  // bookkeeping
  int unsigned fail_count = 0;
  int unsigned items_taken = 0;
  int unsigned msgs_done = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_count = 0;

  // idling control: quiet turns off random gaps and stalls
  bit          quiet = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  sha1_digest dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // sha1 model
  // --------------------------------------------------------------------------

  function automatic word_t rol(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // fresh chaining value and empty length for the next message
  function automatic void begin_message();
    chain_h[0] = H0_INIT;
    chain_h[1] = H1_INIT;
    chain_h[2] = H2_INIT;
    chain_h[3] = H3_INIT;
    chain_h[4] = H4_INIT;
    msg_bits = '0;
    fill_idx = 0;
  endfunction

  // 80 rounds over the 16-word block, folded into the chaining value
  function automatic void compress_block();
    word_t sched [80];
    word_t a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) sched[r] = blk_words[r];
    for (int r = 16; r < 80; r++)
      sched[r] = rol(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY_LO;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = K_PARITY_HI;
      end
      t = rol(a, 5) + f + e + sched[r] + k;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // store one word; a full block gets compressed right away
  function automatic void put_word(input word_t w);
    blk_words[fill_idx] = w;
    fill_idx++;
    if (fill_idx == BufDepth) begin
      compress_block();
      fill_idx = 0;
    end
  endfunction

  // hash one accepted item, queue the five digest items on a final one
  function automatic void hash_item(input word_t w, input logic [2:0] cnt, input logic fin);
    int    nbytes;
    word_t keep;
    if (!fin) begin
      // count is ignored on non-final items, all four bytes go in
      put_word(w);
      msg_bits += 64'd32;
      return;
    end
    nbytes = (cnt > FULL_WORD) ? 4 : int'(cnt);
    msg_bits += 64'(nbytes * 8);
    if (nbytes < 4) begin
      // unused low bytes give way to the 0x80 marker
      keep = (nbytes == 0) ? '0 : ~(32'hffff_ffff >> (8 * nbytes));
      blk_words[fill_idx] = (w & keep) | (32'h80 << (24 - 8 * nbytes));
      fill_idx++;
    end else begin
      put_word(w);
      blk_words[fill_idx] = PAD_MARK;
      fill_idx++;
    end
    // no room for the length field: pad out and spend an extra block
    if (fill_idx > 14) begin
      while (fill_idx < BufDepth) begin
        blk_words[fill_idx] = '0;
        fill_idx++;
      end
      compress_block();
      fill_idx = 0;
    end
    while (fill_idx < 14) begin
      blk_words[fill_idx] = '0;
      fill_idx++;
    end
    blk_words[14] = msg_bits[63:32];
    blk_words[15] = msg_bits[31:0];
    compress_block();
    for (int j = 0; j < HashWords; j++)
      digest_q.push_back('{word: chain_h[j], index: 3'(j), last: (j == HashWords - 1)});
    begin_message();
  endfunction

  initial begin
    begin_message();
    for (int i = 0; i < BufDepth; i++) blk_words[i] = '0;
  end

  // --------------------------------------------------------------------------
  // input side: the model follows every accepted item
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      hash_item(in_data_word, in_byte_count, in_last);
      items_taken++;
      if (in_last) msgs_done++;
    end
  end

  // offer one item and hold it until taken, with an occasional gap ahead
  task automatic send_item(input word_t w, input logic [2:0] cnt, input logic fin);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= w;
    in_byte_count <= cnt;
    in_last       <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // n full words, then a final item with a random count
  // noisy mode puts odd counts on the body words and counts above four at the end
  task automatic send_message(input int unsigned n_words, input bit noisy);
    logic [2:0] cnt;
    for (int unsigned i = 0; i < n_words; i++) begin
      cnt = (noisy && $urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD;
      send_item($urandom, cnt, 1'b0);
    end
    cnt = noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
    send_item($urandom, cnt, 1'b1);
  endtask

  // body lengths that put the final item near the block boundary as often as not
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 4);
      1:       return $urandom_range(12, 17);
      default: return $urandom_range(28, 33);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // output side: ready pattern and result check
  // --------------------------------------------------------------------------

  // random stall bursts of random length; a hold request blocks the output
  // for a long stretch so the block fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void note_failure(input string what);
    if (fail_count < MAX_SHOWN) $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endfunction

  // each digest item against the oldest expected one, field by field
  always @(posedge clk) begin
    digest_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        note_failure($sformatf("unexpected digest item word=%h index=%0d last=%b",
                               out_digest_word, out_word_index, out_last_word));
      end else begin
        want = digest_q.pop_front();
        words_checked++;
        if (out_digest_word !== want.word)
          note_failure($sformatf("digest word index %0d: expected %h, got %h",
                                 want.index, want.word, out_digest_word));
        if (out_word_index !== want.index)
          note_failure($sformatf("word index: expected %0d, got %0d",
                                 want.index, out_word_index));
        if (out_last_word !== want.last)
          note_failure($sformatf("last word flag at index %0d: expected %b, got %b",
                                 want.index, want.last, out_last_word));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // empty message, the classic "abc" and final words of every byte count
  task automatic test_short_messages();
    send_item(32'h0000_0000, 3'd0, 1'b1);
    send_item(32'h6162_6300, 3'd3, 1'b1);
    send_item(32'hffff_ffff, FULL_WORD, 1'b0);
    send_item(32'hffff_ffff, 3'd1, 1'b1);
    send_item(32'h0000_0000, FULL_WORD, 1'b0);
    send_item(32'hffff_ffff, 3'd2, 1'b1);
    send_item(32'hffff_ffff, FULL_WORD, 1'b0);
    send_item(32'h0000_0000, FULL_WORD, 1'b1);
    send_item(32'hffff_ffff, FULL_WORD, 1'b1);
  endtask

  // count field extremes: ignored on body words, saturating on the final one
  task automatic test_count_extremes();
    send_item(32'ha5a5_5a5a, 3'd0, 1'b0);
    send_item(32'h5a5a_a5a5, 3'd7, 1'b0);
    send_item(32'h0123_4567, 3'd5, 1'b0);
    send_item(32'h89ab_cdef, 3'd2, 1'b1);
    send_item(32'hdead_beef, 3'd5, 1'b1);
    send_item(32'h1234_5678, 3'd6, 1'b0);
    send_item(32'hcafe_f00d, 3'd7, 1'b1);
    send_item(32'hffff_ffff, 3'd0, 1'b0);
    send_item(32'hffff_ffff, 3'd6, 1'b1);
  endtask

  // output held off while a full message and most of the next one come in
  task automatic test_output_hold();
    hold_reqs <= hold_reqs + 1;
    send_message(3, 1'b0);
    send_message(20, 1'b0);
    send_message(14, 1'b0);
  endtask

  // random well-formed messages, a share of them with noisy counts
  task automatic test_random_messages(input int unsigned n_items);
    int unsigned start;
    start = items_taken;
    while (items_taken - start < n_items)
      send_message(pick_length(), $urandom_range(0, 3) == 0);
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_streaming();
    quiet = 1'b1;
    send_message(15, 1'b0);
    send_message(13, 1'b0);
    send_message(1, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_messages();
    test_count_extremes();
    test_output_hold();
    test_random_messages(60);
    test_streaming();

    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d messages in %0d input items, %0d digest words compared",
             msgs_done, items_taken, words_checked);
    $display("failures counted: %0d", fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digest items still expected",
             cycle_count, digest_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
